@@ rtl/lifo_pkg.sv @@
// ----------------------------------------------------------------------------
// lifo_pkg: shared types and constants of the LIFO stack engine
// Sizes, action and status codes, sequencer states and the store port bundles.
// ----------------------------------------------------------------------------
package lifo_pkg;

   // Number of words the stack holds (2 to 64)
   localparam int STACK_DEPTH = 32;

   localparam int ADDR_W   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W    = $clog2(STACK_DEPTH + 1);
   localparam int VALUE_W  = 32;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;
   localparam int INDEX_W  = 6;
   localparam int FILL_W   = 7;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_TOP   = 3'd2,
      ACT_DUP   = 3'd3,
      ACT_SWAP  = 3'd4,
      ACT_CLEAR = 3'd5,
      ACT_DUMP  = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FEW  = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_RD,
      S_TOP_RD,
      S_DUP_RD,
      S_SWP_1,
      S_SWP_2,
      S_SWP_3,
      S_DUMP
   } state_type;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [VALUE_W-1:0] data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

endpackage

@@ rtl/lifo_ram.sv @@
// ----------------------------------------------------------------------------
// lifo_ram: entry store of the stack
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module lifo_ram (
   input  logic                            clock,
   input  lifo_pkg::ram_wr_type            wr,
   input  lifo_pkg::ram_rd_type            rd,
   output logic [lifo_pkg::VALUE_W-1:0]    rd_data
);
   import lifo_pkg::*;

   logic [VALUE_W-1:0] mem [STACK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

@@ rtl/bounded_lifo_stack_engine.sv @@
// ----------------------------------------------------------------------------
// bounded_lifo_stack_engine: bounded LIFO stack of signed 32-bit words
// Push, pop, top, dup, swap, clear and dump over a single-port-pair store.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake              beat contents
//   req       in         start & !busy          action, operand_value
//   rsp       out        rsp_strobe (1 cycle)   status, result_value,
//                                               entry_index, fill_count, last
//
// Work: push, clear, error cases and the unused code finish at accept; pop, top
// and dup do one store read; swap does two reads and two writes through the
// single write port; dump walks the stack top-down, one entry per cycle.
// Each result beat appears the cycle after its work completes.
// Reset (synchronous) empties the stack; stored words stay undefined.
// The receiver cannot stall: every result beat is taken when shown.
//
module bounded_lifo_stack_engine (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [lifo_pkg::ACTION_W-1:0]         req_action,
   input  logic signed [lifo_pkg::VALUE_W-1:0]   req_operand_value,
   output logic                                  rsp_strobe,
   output logic [lifo_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [lifo_pkg::VALUE_W-1:0]   rsp_result_value,
   output logic [lifo_pkg::INDEX_W-1:0]          rsp_entry_index,
   output logic [lifo_pkg::FILL_W-1:0]           rsp_fill_count,
   output logic                                  rsp_last
);
   import lifo_pkg::*;

   // control state
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               strobe_ff, strobe_in;

   // datapath registers
   logic [ADDR_W-1:0]  idx_ff, idx_in;     // dump walk position
   logic [VALUE_W-1:0] tmp_ff, tmp_in;     // old top during swap

   // result beat registers
   status_type         status_ff, status_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               last_ff, last_in;

   // store ports
   ram_wr_type         ram_wr;
   ram_rd_type         ram_rd;
   logic [VALUE_W-1:0] ram_rd_data;

   logic               accept;
   logic               is_empty, is_full, has_two;
   logic [ADDR_W-1:0]  top_addr, below_addr, free_addr;
   action_type         act;

   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign act      = action_type'(req_action);

   assign is_empty = (cnt_ff == '0);
   assign is_full  = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign has_two  = (cnt_ff >= CNT_W'(2));

   // top = n-1, below = n-2, free slot = n (only used when not full)
   assign top_addr   = ADDR_W'(cnt_ff - CNT_W'(1));
   assign below_addr = ADDR_W'(cnt_ff - CNT_W'(2));
   assign free_addr  = ADDR_W'(cnt_ff);

   lifo_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (act)
                  ACT_POP:  state_in = is_empty ? S_IDLE : S_POP_RD;
                  ACT_TOP:  state_in = is_empty ? S_IDLE : S_TOP_RD;
                  ACT_DUP:  state_in = (is_empty || is_full) ? S_IDLE : S_DUP_RD;
                  ACT_SWAP: state_in = has_two ? S_SWP_1 : S_IDLE;
                  ACT_DUMP: state_in = is_empty ? S_IDLE : S_DUMP;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_POP_RD: state_in = S_IDLE;
         S_TOP_RD: state_in = S_IDLE;
         S_DUP_RD: state_in = S_IDLE;
         S_SWP_1:  state_in = S_SWP_2;
         S_SWP_2:  state_in = S_SWP_3;
         S_SWP_3:  state_in = S_IDLE;
         S_DUMP:   state_in = (idx_ff == '0) ? S_IDLE : S_DUMP;
         default:  state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      tmp_in    = tmp_ff;
      strobe_in = 1'b0;
      status_in = ST_OK;
      value_in  = '0;
      index_in  = '0;
      fill_in   = FILL_W'(cnt_ff);
      last_in   = 1'b1;
      ram_wr    = '0;
      ram_rd    = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (act)
                  ACT_PUSH: begin
                     strobe_in = 1'b1;
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        ram_wr.en   = 1'b1;
                        ram_wr.addr = free_addr;
                        ram_wr.data = $unsigned(req_operand_value);
                        cnt_in      = cnt_ff + CNT_W'(1);
                        fill_in     = FILL_W'(cnt_ff + CNT_W'(1));
                     end
                  end
                  ACT_POP: begin
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = ST_FEW;
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = top_addr;
                        cnt_in      = cnt_ff - CNT_W'(1);
                     end
                  end
                  ACT_TOP, ACT_DUP: begin
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = ST_FEW;
                     end else if (act == ACT_DUP && is_full) begin
                        strobe_in = 1'b1;
                        status_in = ST_FULL;
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = top_addr;
                     end
                  end
                  ACT_SWAP: begin
                     if (!has_two) begin
                        strobe_in = 1'b1;
                        status_in = ST_FEW;
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = top_addr;
                     end
                  end
                  ACT_CLEAR: begin
                     strobe_in = 1'b1;
                     cnt_in    = '0;
                     fill_in   = '0;
                  end
                  ACT_DUMP: begin
                     if (is_empty) begin
                        strobe_in = 1'b1;
                        status_in = ST_FEW;
                     end else begin
                        ram_rd.en   = 1'b1;
                        ram_rd.addr = top_addr;
                        idx_in      = top_addr;
                     end
                  end
                  default: begin
                     // unused code: plain ok beat, nothing changes
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_POP_RD, S_TOP_RD: begin
            // pop already dropped the count at accept
            strobe_in = 1'b1;
            value_in  = ram_rd_data;
         end
         S_DUP_RD: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = free_addr;
            ram_wr.data = ram_rd_data;
            cnt_in      = cnt_ff + CNT_W'(1);
            strobe_in   = 1'b1;
            fill_in     = FILL_W'(cnt_ff + CNT_W'(1));
         end
         S_SWP_1: begin
            tmp_in      = ram_rd_data;
            ram_rd.en   = 1'b1;
            ram_rd.addr = below_addr;
         end
         S_SWP_2: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = top_addr;
            ram_wr.data = ram_rd_data;
         end
         S_SWP_3: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = below_addr;
            ram_wr.data = tmp_ff;
            strobe_in   = 1'b1;
         end
         S_DUMP: begin
            strobe_in = 1'b1;
            value_in  = ram_rd_data;
            index_in  = INDEX_W'(idx_ff);
            last_in   = (idx_ff == '0);
            if (idx_ff != '0) begin
               ram_rd.en   = 1'b1;
               ram_rd.addr = idx_ff - ADDR_W'(1);
               idx_in      = idx_ff - ADDR_W'(1);
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         cnt_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      tmp_ff    <= tmp_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      index_ff  <= index_in;
      fill_ff   <= fill_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_result_value = $signed(value_ff);
   assign rsp_entry_index  = index_ff;
   assign rsp_fill_count   = fill_ff;
   assign rsp_last         = last_ff;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_dump_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DUMP |=> rsp_strobe)
      else $error("dump step without result beat");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_entry_index != '0) |-> !rsp_last)
      else $error("last set on a non-bottom dump beat");

   a_push_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && act == ACT_PUSH && !is_full) |=>
         cnt_ff == CNT_W'($past(cnt_ff) + CNT_W'(1)))
      else $error("push did not grow the stack");
`endif

endmodule

@@ test/tb_bounded_lifo_stack_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_lifo_stack_engine: self-checking bench for the LIFO stack engine
// Drives push/pop/top/dup/swap/clear/dump commands with random idle gaps and
// compares every response beat against an in-bench stack model.
// ----------------------------------------------------------------------------
module tb_bounded_lifo_stack_engine;

   localparam int DEPTH       = lifo_pkg::STACK_DEPTH;
   localparam int VW          = lifo_pkg::VALUE_W;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 446;
   localparam int QUIET_TAIL  = 60;          // last items go back to back
   localparam int PRINT_CAP   = 100;

   // code 7 is not decoded: behaves as a no-op with one ok beat
   localparam logic [lifo_pkg::ACTION_W-1:0] ACT_NOP = 3'd7;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_mode_type;

   typedef struct {
      logic [lifo_pkg::STATUS_W-1:0] status;
      logic [VW-1:0]                 value;
      logic [lifo_pkg::INDEX_W-1:0]  index;
      logic [lifo_pkg::FILL_W-1:0]   fill;
      logic                          last;
   } rsp_beat_type;

   // -------------------------------------------------------------------------
   // Stack model plus queue of awaited response beats
   // -------------------------------------------------------------------------
   class stack_scoreboard;
      logic [VW-1:0] entries [DEPTH];
      int unsigned   fill_level;
      rsp_beat_type  awaited_beats [$];
      int            errors;
      int            beat_no;

      function new();
         fill_level = 0;
         errors     = 0;
         beat_no    = 0;
      endfunction

      function void add_beat(lifo_pkg::status_type st, logic [VW-1:0] val,
                             int unsigned idx, bit lst);
         rsp_beat_type b;
         b.status = st;
         b.value  = val;
         b.index  = idx[lifo_pkg::INDEX_W-1:0];
         b.fill   = fill_level[lifo_pkg::FILL_W-1:0];
         b.last   = lst;
         awaited_beats.push_back(b);
      endfunction

      // apply one accepted command and queue the beats it must produce
      function void note_request(logic [lifo_pkg::ACTION_W-1:0] act,
                                 logic [VW-1:0] opnd);
         lifo_pkg::status_type st;
         logic [VW-1:0]        val;
         logic [VW-1:0]        tmp;
         st  = lifo_pkg::ST_OK;
         val = '0;
         case (act)
            lifo_pkg::ACT_PUSH: begin
               if (fill_level >= DEPTH) st = lifo_pkg::ST_FULL;
               else begin
                  entries[fill_level] = opnd;
                  fill_level++;
               end
            end
            lifo_pkg::ACT_POP: begin
               if (fill_level == 0) st = lifo_pkg::ST_FEW;
               else begin
                  val = entries[fill_level-1];
                  fill_level--;
               end
            end
            lifo_pkg::ACT_TOP: begin
               if (fill_level == 0) st = lifo_pkg::ST_FEW;
               else val = entries[fill_level-1];
            end
            lifo_pkg::ACT_DUP: begin
               if (fill_level == 0) st = lifo_pkg::ST_FEW;
               else if (fill_level >= DEPTH) st = lifo_pkg::ST_FULL;
               else begin
                  entries[fill_level] = entries[fill_level-1];
                  fill_level++;
               end
            end
            lifo_pkg::ACT_SWAP: begin
               if (fill_level < 2) st = lifo_pkg::ST_FEW;
               else begin
                  tmp                   = entries[fill_level-1];
                  entries[fill_level-1] = entries[fill_level-2];
                  entries[fill_level-2] = tmp;
               end
            end
            lifo_pkg::ACT_CLEAR: fill_level = 0;
            lifo_pkg::ACT_DUMP: begin
               if (fill_level == 0) st = lifo_pkg::ST_FEW;
               else begin
                  // walk from the top index down, last on index 0
                  for (int i = int'(fill_level) - 1; i >= 0; i--)
                     add_beat(lifo_pkg::ST_OK, entries[i], i, i == 0);
                  return;
               end
            end
            default: ;
         endcase
         add_beat(st, val, 0, 1'b1);
      endfunction

      task report(string msg);
         if (errors < PRINT_CAP) $display("MISMATCH beat %0d: %s", beat_no, msg);
         errors++;
      endtask

      task check_beat(rsp_beat_type got);
         rsp_beat_type want;
         if (awaited_beats.size() == 0) begin
            report($sformatf("unexpected beat status=%0d value=%0h idx=%0d",
                             got.status, got.value, got.index));
         end else begin
            want = awaited_beats.pop_front();
            if (got.status !== want.status)
               report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.value !== want.value)
               report($sformatf("value %0h, want %0h", got.value, want.value));
            if (got.index !== want.index)
               report($sformatf("index %0d, want %0d", got.index, want.index));
            if (got.fill !== want.fill)
               report($sformatf("fill %0d, want %0d", got.fill, want.fill));
            if (got.last !== want.last)
               report($sformatf("last %0b, want %0b", got.last, want.last));
         end
         beat_no++;
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, DUT
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   always #5 clock = ~clock;

   logic                                 reset;
   logic                                 start;
   logic                                 busy;
   logic [lifo_pkg::ACTION_W-1:0]        req_action;
   logic signed [VW-1:0]                 req_operand_value;
   logic                                 rsp_strobe;
   logic [lifo_pkg::STATUS_W-1:0]        rsp_status;
   logic signed [VW-1:0]                 rsp_result_value;
   logic [lifo_pkg::INDEX_W-1:0]         rsp_entry_index;
   logic [lifo_pkg::FILL_W-1:0]          rsp_fill_count;
   logic                                 rsp_last;

   bounded_lifo_stack_engine u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_operand_value (req_operand_value),
      .rsp_strobe        (rsp_strobe),
      .rsp_status        (rsp_status),
      .rsp_result_value  (rsp_result_value),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_last          (rsp_last)
   );

   stack_scoreboard stack_sb = new();
   int              cycle_count = 0;
   bit              gaps_on;

   // -------------------------------------------------------------------------
   // Watchdog: a hung engine or a lost beat ends here
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: strobe is a one-cycle pulse, take every beat shown.
   // Sampled at the edge, so we see pre-edge values of the DUT flops.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_beat_type b;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         b.status = rsp_status;
         b.value  = rsp_result_value;
         b.index  = rsp_entry_index;
         b.fill   = rsp_fill_count;
         b.last   = rsp_last;
         stack_sb.check_beat(b);
      end
   end

   // -------------------------------------------------------------------------
   // Command driver. Called in the time step of the previous accept edge, so
   // start gets exactly one NBA per step: either dropped for a gap, or kept
   // high with the new beat.
   // -------------------------------------------------------------------------
   task send_request(logic [lifo_pkg::ACTION_W-1:0] act, logic [VW-1:0] opnd);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      start             <= 1'b1;
      req_action        <= act;
      req_operand_value <= opnd;
      // accepted on the edge where start is high and busy was low
      do @(posedge clock); while (busy !== 1'b0);
      stack_sb.note_request(act, opnd);
   endtask

   // extremes show up often; the rest is full-width random
   function logic [VW-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // weighted choice of the next command, steered by mode and current fill
   function logic [lifo_pkg::ACTION_W-1:0] pick_action(mix_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MIX_FILL: begin
            if (stack_sb.fill_level < DEPTH) begin
               if (r < 70)      return lifo_pkg::ACT_PUSH;
               else if (r < 85) return lifo_pkg::ACT_DUP;
               else if (r < 92) return lifo_pkg::ACT_SWAP;
               else if (r < 97) return lifo_pkg::ACT_TOP;
               else             return lifo_pkg::ACT_DUMP;
            end else begin
               // pound on the full stack: overflow, dup-full, swap-full
               if (r < 30)      return lifo_pkg::ACT_PUSH;
               else if (r < 55) return lifo_pkg::ACT_DUP;
               else if (r < 75) return lifo_pkg::ACT_SWAP;
               else if (r < 85) return lifo_pkg::ACT_TOP;
               else if (r < 92) return lifo_pkg::ACT_DUMP;
               else             return lifo_pkg::ACT_POP;
            end
         end
         MIX_DRAIN: begin
            if (r < 60)      return lifo_pkg::ACT_POP;
            else if (r < 70) return lifo_pkg::ACT_TOP;
            else if (r < 80) return lifo_pkg::ACT_SWAP;
            else if (r < 88) return lifo_pkg::ACT_DUMP;
            else if (r < 96) return lifo_pkg::ACT_PUSH;
            else             return lifo_pkg::ACT_CLEAR;
         end
         default: begin
            // noise, incl. code 7
            r = $urandom_range(0, 7);
            return r[lifo_pkg::ACTION_W-1:0];
         end
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      mix_mode_type mode;
      int           seg_left;

      reset             <= 1'b1;
      start             <= 1'b0;
      req_action        <= lifo_pkg::ACT_PUSH;
      req_operand_value <= '0;
      gaps_on           = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty-stack errors, one-entry swap, extremes, clear
      send_request(lifo_pkg::ACT_DUMP,  '0);
      send_request(lifo_pkg::ACT_POP,   '0);
      send_request(lifo_pkg::ACT_TOP,   '0);
      send_request(lifo_pkg::ACT_DUP,   '0);
      send_request(lifo_pkg::ACT_SWAP,  '0);
      send_request(ACT_NOP,             32'hffff_ffff);
      send_request(lifo_pkg::ACT_PUSH,  32'h8000_0000);
      send_request(lifo_pkg::ACT_SWAP,  '0);           // only one entry
      send_request(lifo_pkg::ACT_DUP,   '0);
      send_request(lifo_pkg::ACT_PUSH,  32'h7fff_ffff);
      send_request(lifo_pkg::ACT_SWAP,  32'h1234_5678);
      send_request(lifo_pkg::ACT_TOP,   '0);
      send_request(lifo_pkg::ACT_DUMP,  '0);
      send_request(ACT_NOP,             '0);
      send_request(lifo_pkg::ACT_POP,   '0);
      send_request(lifo_pkg::ACT_POP,   '0);
      send_request(lifo_pkg::ACT_POP,   '0);
      send_request(lifo_pkg::ACT_POP,   '0);           // empty again
      send_request(lifo_pkg::ACT_PUSH,  32'h0000_0000);
      send_request(lifo_pkg::ACT_PUSH,  32'hffff_ffff);
      send_request(lifo_pkg::ACT_CLEAR, '0);
      send_request(lifo_pkg::ACT_TOP,   '0);           // nothing after clear
      send_request(lifo_pkg::ACT_PUSH,  32'h5555_5555);
      send_request(lifo_pkg::ACT_PUSH,  32'haaaa_aaaa);
      send_request(lifo_pkg::ACT_DUMP,  '0);

      // random: segments of fill / drain / noise; fill runs reach full
      mode     = MIX_FILL;
      seg_left = $urandom_range(40, 60);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (seg_left == 0) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: mode = MIX_FILL;
               4, 5, 6:    mode = MIX_DRAIN;
               default:    mode = MIX_ANY;
            endcase
            seg_left = (mode == MIX_FILL) ? $urandom_range(40, 60)
                                          : $urandom_range(15, 40);
         end
         seg_left--;
         gaps_on = (i < RANDOM_ITEMS - QUIET_TAIL);
         send_request(pick_action(mode), pick_operand());
      end
      start <= 1'b0;

      // drain: every awaited beat in, then wait for stray strobes
      while (stack_sb.awaited_beats.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (stack_sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
